FILE: rtl/frgb_pkg.sv
// Package for the framed RGB LED PWM core: item and result types, header codes,
// channel count and widths. Used by every module in rtl/, depends on nothing.
`timescale 1ns / 1ps

package frgb_pkg;

   // Number of brightness channels kept by the core.
   localparam int CHANNELS    = 6;
   // Width of the reported LED pattern; bits 0..2 are the first LED, 3..5 the second.
   localparam int PATTERN_W   = 6;
   // Colors carried by one frame.
   localparam int LED_COLORS  = 3;
   localparam int LEVEL_W     = 8;

   localparam logic [LEVEL_W-1:0] HDR_FIRST_LED  = 8'd255;
   localparam logic [LEVEL_W-1:0] HDR_SECOND_LED = 8'd254;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_FRAME = 1'b1
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [LEVEL_W-1:0]   header;
      logic [LEVEL_W-1:0]   red_level;
      logic [LEVEL_W-1:0]   green_level;
      logic [LEVEL_W-1:0]   blue_level;
   } item_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] led_pattern;
      logic [LEVEL_W-1:0]   pwm_phase;
   } result_type;

endpackage

FILE: rtl/framed_rgb_led_pwm_core.sv
// Top level of the framed RGB LED PWM core: input stage, LED state, result register.
// Depends on frgb_pkg, frgb_in_stage and frgb_led_state.
`timescale 1ns / 1ps

// The core drives two RGB LEDs through six 8-bit PWM channels, all at zero
// brightness after reset, compared against one shared 8-bit phase that starts
// at zero. Each request transaction is either a tick (req_tuser = 0), which
// reports the pattern against the current phase and then advances the phase
// with wrap from 255 to 0, or a frame (req_tuser = 1), whose header 255 loads
// the first LED's red, green and blue levels and whose header 254 loads the
// second LED's; other headers load nothing. The frame's pattern already uses
// the new levels. Every request transaction yields exactly one response
// transaction with the 6-bit pattern (bit j set when level j exceeds the phase)
// and the phase that was compared. The core accepts one transaction per clock
// cycle; each passes through the input register and then the response
// register, with the level update, compare and phase advance done in
// between. While a response waits for rsp_tready, nothing moves into the
// response register, but an empty input register still takes one more
// transaction; req_tready drops only once both registers are full, so
// throughput only drops when the response side stalls.

module framed_rgb_led_pwm_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // header[7:0], red_level[15:8], green_level[23:16],
                                   // blue_level[31:24]
   input  logic        req_tuser,  // op[0]: 0 tick, 1 frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // led_pattern[5:0], pwm_phase[13:6], zero[15:14]
);
   import frgb_pkg::*;

   item_type   req_item;
   item_type   s1_item;
   logic       s1_valid;
   logic       s1_fire;
   logic       s2_ready;
   result_type result;
   logic [7:0] cur_phase;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_item.op          = op_type'(req_tuser);
   assign req_item.header      = req_tdata[7:0];
   assign req_item.red_level   = req_tdata[15:8];
   assign req_item.green_level = req_tdata[23:16];
   assign req_item.blue_level  = req_tdata[31:24];

   // The response register takes a new result when empty or being drained.
   assign s2_ready = !rsp_valid_ff || rsp_tready;
   assign s1_fire  = s1_valid && s2_ready;

   frgb_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_ready (s2_ready),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   // State changes exactly when an item moves into the response register,
   // which keeps the updates in transaction order.
   frgb_led_state u_led_state (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_item),
      .result (result),
      .phase  (cur_phase)
   );

   assign rsp_valid_in = s2_ready ? s1_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.pwm_phase, rsp_ff.led_pattern};

`ifndef SYNTHESIS
   // A tick that moves forward advances the phase by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_item.op == OP_TICK)) |=> (cur_phase == 8'($past(cur_phase) + 8'd1)))
      else $error("phase did not advance after a tick");

   // Frames and idle cycles leave the phase alone.
   assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && (s1_item.op == OP_TICK)) |=> $stable(cur_phase))
      else $error("phase changed without a tick");

   // The response reports the phase that was current when the item moved forward.
   assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (rsp_ff.pwm_phase == $past(cur_phase)))
      else $error("response phase does not match the compared phase");

   // The input side only stalls while the input register holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid && rsp_valid_ff && !rsp_tready))
      else $error("request side stalled without a full pipeline");
`endif

endmodule

FILE: rtl/frgb_in_stage.sv
// Input register stage of the framed RGB LED PWM core.
// Captures one request transaction per cycle unless full while the output side stalls; depends on frgb_pkg.
`timescale 1ns / 1ps

module frgb_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  frgb_pkg::item_type in_item,
   input  logic               out_ready,
   output logic               out_valid,
   output frgb_pkg::item_type out_item
);
   import frgb_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The stage can take a new transaction when empty or when it empties this cycle.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

FILE: rtl/frgb_led_state.sv
// Brightness levels, PWM phase and pattern compare of the framed RGB LED PWM core.
// Updates state once per fired item; depends on frgb_pkg.
`timescale 1ns / 1ps

module frgb_led_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  frgb_pkg::item_type   item,
   output frgb_pkg::result_type result,
   output logic [7:0]           phase
);
   import frgb_pkg::*;

   logic [LEVEL_W-1:0]   phase_ff;
   logic [LEVEL_W-1:0]   phase_in;
   logic [LEVEL_W-1:0]   colors [LED_COLORS];
   logic [LEVEL_W-1:0]   level_in [CHANNELS];
   logic                 hit_first;
   logic                 hit_second;
   logic [PATTERN_W-1:0] pattern;

   assign colors[0] = item.red_level;
   assign colors[1] = item.green_level;
   assign colors[2] = item.blue_level;

   assign hit_first  = (item.op == OP_FRAME) && (item.header == HDR_FIRST_LED);
   assign hit_second = (item.op == OP_FRAME) && (item.header == HDR_SECOND_LED);

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
      logic [LEVEL_W-1:0] level_ff;

      // A frame's new levels are used for its own pattern.
      if (ch < LED_COLORS) begin : g_first
         assign level_in[ch] = hit_first ? colors[ch] : level_ff;
      end else if (ch < 2 * LED_COLORS) begin : g_second
         assign level_in[ch] = hit_second ? colors[ch - LED_COLORS] : level_ff;
      end else begin : g_spare
         assign level_in[ch] = level_ff;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            level_ff <= '0;
         end else if (fire) begin
            level_ff <= level_in[ch];
         end
      end
   end

   for (genvar j = 0; j < PATTERN_W; j++) begin : g_pat
      if (j < CHANNELS) begin : g_cmp
         assign pattern[j] = level_in[j] > phase_ff;
      end else begin : g_zero
         assign pattern[j] = 1'b0;
      end
   end

   // The phase advances after a tick has been compared against it.
   assign phase_in = (item.op == OP_TICK) ? LEVEL_W'(phase_ff + 8'd1) : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
   end

   assign result.led_pattern = pattern;
   assign result.pwm_phase   = phase_ff;
   assign phase              = phase_ff;

endmodule
